### rtl/qrs_pkg.sv
// shared types and constants for the queue with running stats block
// no dependencies
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int VAL_W   = 32;
  localparam int TOTAL_W = 36;
  localparam int POS_W   = 5;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // control from the sequencer to the min/max compare unit
  typedef struct packed {
    logic             clear;
    logic             feed;
    logic [POS_W-1:0] pos;
  } mm_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]        min_pos;
    logic signed [VAL_W-1:0] min_value;
    logic [POS_W-1:0]        max_pos;
    logic signed [VAL_W-1:0] max_value;
  } mm_res_t;

endpackage

### rtl/queue_with_running_stats_core.sv
// bounded fifo with running sum and min/max rescan, one word in, one word out
// sequence: update, a pop-subtract step when a pop removes a word, a scan of every held entry
//   (one entry per cycle through the single read port of the store), query, then finish
// a new word is taken only in idle, once the finish step has handed off the last result;
//   finish waits while an earlier result is still stalled at the output
// reset: synchronous, clears state, head, fill count, running sum and valid; store contents undefined
`timescale 1ns / 1ps

module queue_with_running_stats_core
  import qrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic signed [VAL_W-1:0]   value,
  input  logic [4:0]                query_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [4:0]                count,
  output logic signed [TOTAL_W-1:0] total,
  output logic signed [4:0]         min_pos,
  output logic signed [VAL_W-1:0]   min_value,
  output logic signed [4:0]         max_pos,
  output logic signed [VAL_W-1:0]   max_value,
  output logic signed [VAL_W-1:0]   query_value,
  output logic                      query_found,
  output logic                      overflow
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_POP_SUB,
    S_SCAN,
    S_QUERY,
    S_FINISH
  } state_t;

  state_t                    state;
  logic [AW-1:0]             head;
  logic [CW-1:0]             fill;
  logic signed [TOTAL_W-1:0] sum;
  logic [1:0]                op_r;
  logic signed [VAL_W-1:0]   value_r;
  logic [4:0]                qidx;
  logic                      ovf;
  logic [CW-1:0]             scan_pos;
  logic                      rd_feed;
  logic [POS_W-1:0]          rd_pos;

  logic [AW-1:0]             pos_sel;
  logic [AW:0]               addr_sum;
  logic [AW-1:0]             addr;
  logic                      push_ok;
  logic                      we;
  logic signed [VAL_W-1:0]   rdata;
  logic [PW-1:0]             scan_pos_ext;
  logic [PW-1:0]             fill_ext;
  logic                      qhit;
  mm_ctl_t                   mm_ctl;
  mm_res_t                   mm_res;

  assign in_ready     = (state == S_IDLE);
  assign push_ok      = (fill < DEPTH_C);
  assign scan_pos_ext = PW'(scan_pos);
  assign fill_ext     = PW'(fill);
  assign qhit         = (PW'(qidx) < fill_ext);

  // shared slot adder: head plus position, wrapped at the queue depth
  always_comb begin
    case (state)
      S_UPDATE: pos_sel = (op_r == OP_POP) ? '0 : fill[AW-1:0];
      S_SCAN:   pos_sel = scan_pos[AW-1:0];
      default:  pos_sel = AW'(qidx) & {AW{qhit}};
    endcase
    addr_sum = {1'b0, head} + {1'b0, pos_sel};
    if (addr_sum >= DEPTH_A) begin
      addr = AW'(addr_sum - DEPTH_A);
    end else begin
      addr = addr_sum[AW-1:0];
    end
  end

  assign we = (state == S_UPDATE) && (op_r == OP_PUSH) && push_ok;

  qrs_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (value_r),
    .raddr (addr),
    .rdata (rdata)
  );

  assign mm_ctl.clear = (state == S_UPDATE);
  assign mm_ctl.feed  = rd_feed;
  assign mm_ctl.pos   = rd_pos;

  qrs_minmax u_minmax (
    .clk (clk),
    .rst (rst),
    .ctl (mm_ctl),
    .din (rdata),
    .res (mm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      rd_feed   <= 1'b0;
    end else begin
      rd_feed <= (state == S_SCAN);
      rd_pos  <= scan_pos_ext[POS_W-1:0];
      // the finish state handles its own handoff of the output word
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op;
            value_r <= value;
            qidx    <= query_index;
            state   <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          scan_pos <= '0;
          ovf      <= (op_r == OP_PUSH) && !push_ok;
          if (op_r == OP_PUSH && push_ok) begin
            fill  <= fill + 1'b1;
            sum   <= sum + TOTAL_W'(value_r);
            state <= S_SCAN;
          end else if (op_r == OP_POP && fill != '0) begin
            state <= S_POP_SUB;
          end else if (fill == '0) begin
            state <= S_QUERY;
          end else begin
            state <= S_SCAN;
          end
        end
        S_POP_SUB: begin
          // head word read back during the update cycle
          sum   <= sum - TOTAL_W'(rdata);
          head  <= (head == LAST_A) ? '0 : head + 1'b1;
          fill  <= fill - 1'b1;
          state <= (fill == CW'(1)) ? S_QUERY : S_SCAN;
        end
        S_SCAN: begin
          scan_pos <= scan_pos + 1'b1;
          if (scan_pos == fill - 1'b1) begin
            state <= S_QUERY;
          end
        end
        S_QUERY: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // read address still points at the query slot, so rdata holds
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            count       <= fill_ext[POS_W-1:0];
            total       <= sum;
            min_pos     <= mm_res.min_pos;
            min_value   <= mm_res.min_value;
            max_pos     <= mm_res.max_pos;
            max_value   <= mm_res.max_value;
            query_found <= qhit;
            query_value <= qhit ? rdata : '1;
            overflow    <= ovf;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/qrs_ram.sv
// entry store: one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module qrs_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [31:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/qrs_minmax.sv
// shared compare unit: tracks first minimum and first maximum over a scan
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_minmax
  import qrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mm_ctl_t                 ctl,
  input  logic signed [VAL_W-1:0] din,
  output mm_res_t                 res
);

  logic                    any;
  logic signed [VAL_W-1:0] lo;
  logic signed [VAL_W-1:0] hi;
  logic [POS_W-1:0]        lo_pos;
  logic [POS_W-1:0]        hi_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (ctl.clear) begin
      any <= 1'b0;
    end else if (ctl.feed) begin
      any <= 1'b1;
      // strict compares so the entry nearest the head wins a tie
      if (!any || din < lo) begin
        lo     <= din;
        lo_pos <= ctl.pos;
      end
      if (!any || din > hi) begin
        hi     <= din;
        hi_pos <= ctl.pos;
      end
    end
  end

  always_comb begin
    if (any) begin
      res.min_pos   = lo_pos;
      res.min_value = lo;
      res.max_pos   = hi_pos;
      res.max_value = hi;
    end else begin
      res.min_pos   = '1;
      res.min_value = '0;
      res.max_pos   = '1;
      res.max_value = '0;
    end
  end

endmodule

### rtl/qrs_checker.sv
// port-level checks for queue_with_running_stats_core, attached by bind
// depends on qrs_pkg
`timescale 1ns / 1ps

module qrs_checker
  import qrs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [4:0]                count,
  input logic signed [TOTAL_W-1:0] total,
  input logic signed [4:0]         min_pos,
  input logic signed [4:0]         max_pos,
  input logic signed [VAL_W-1:0]   query_value,
  input logic                      query_found,
  input logic                      overflow
);

  localparam logic [4:0] DEPTH_5 = 5'(QUEUE_DEPTH);
  localparam bit         WRAPS   = (QUEUE_DEPTH >= 32);

  // one word in flight: no new word right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count) && $stable(total))
    else $error("stalled result word changed");

  // empty queue reports no min/max position, nonempty reports one (checked for depths below 32)
  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    out_valid && !WRAPS |-> ((count == 5'd0) == (min_pos == -5'sd1)) &&
                            ((count == 5'd0) == (max_pos == -5'sd1)))
    else $error("min/max position disagrees with count");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> count == DEPTH_5)
    else $error("overflow reported while queue not full");

  a_query_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !query_found |-> query_value == -32'sd1)
    else $error("missed query does not read as all ones");

endmodule

bind queue_with_running_stats_core qrs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_qrs_checker (.*);
